[design/lfu_cache_table_defines.svh]
// lfu_cache_table_defines.svh: assertion macros
`ifndef LFU_CACHE_TABLE_DEFINES_SVH
`define LFU_CACHE_TABLE_DEFINES_SVH
// implication checked on every clock unless in reset
`define LFU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define LFU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[design/lfu_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfu_pkg
// Shared constants and types of the LFU cache table.
// ---------------------------------------------------------------------------
package lfu_pkg;
   localparam int ENTRIES    = 16;
   localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CAP_BITS   = 5;
   localparam int COUNT_BITS = 16;
   localparam int RANK_BITS  = IDX_BITS;
   localparam int CNT_BITS   = $clog2(ENTRIES + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef struct packed {
      logic scan_start;
      logic scan_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
   } status_type;
endpackage

[design/lfu_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfu_datapath
// Entry storage, serial scan for hit and victim, and the update commit.
// ---------------------------------------------------------------------------
module lfu_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  lfu_pkg::cmd_type         cmd,
   output lfu_pkg::status_type      status,
   input  logic                     load,
   input  logic                     op,
   input  logic [31:0]              key,
   input  logic [31:0]              value,
   input  logic [lfu_pkg::CAP_BITS-1:0] capacity,
   output logic                     found,
   output logic [31:0]              read_value,
   output logic                     evicted,
   output logic [31:0]              evicted_key
);
   localparam int IB = lfu_pkg::IDX_BITS;
   localparam int RB = lfu_pkg::RANK_BITS;
   localparam int CB = lfu_pkg::COUNT_BITS;
   localparam int NB = lfu_pkg::CNT_BITS;

   logic [lfu_pkg::ENTRIES-1:0] valid_ff;
   logic [31:0]   key_mem [lfu_pkg::ENTRIES];
   logic [31:0]   data_mem [lfu_pkg::ENTRIES];
   logic [CB-1:0] count_ff [lfu_pkg::ENTRIES];
   logic [RB-1:0] rank_ff [lfu_pkg::ENTRIES];

   logic          op_ff;
   logic [31:0]   key_ff, value_ff;
   logic [IB-1:0] idx_ff;
   logic          hit_ff, free_ok_ff, vic_ok_ff;
   logic [IB-1:0] hit_idx_ff, free_idx_ff, vic_idx_ff;
   logic [NB-1:0] held_ff;
   logic [CB-1:0] vic_cnt_ff;
   logic [RB-1:0] vic_rank_ff;
   logic [NB-1:0] cap_eff;

   logic          ev, is_hit;
   logic [CB-1:0] ec;
   logic [RB-1:0] er;
   logic [31:0]   ek;

   assign cap_eff = (capacity > lfu_pkg::CAP_BITS'(lfu_pkg::ENTRIES)) ?
                    NB'(lfu_pkg::ENTRIES) : NB'(capacity);
   assign status.scan_last = (idx_ff == IB'(lfu_pkg::ENTRIES - 1));

   assign ev = valid_ff[idx_ff];
   assign ek = key_mem[idx_ff];
   assign ec = count_ff[idx_ff];
   assign er = rank_ff[idx_ff];

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff    <= op;
         key_ff   <= key;
         value_ff <= value;
      end
      if (cmd.scan_start) begin
         idx_ff <= '0;
         hit_ff <= 1'b0;
         free_ok_ff <= 1'b0;
         vic_ok_ff <= 1'b0;
         held_ff <= '0;
      end else if (cmd.scan_step) begin
         idx_ff <= idx_ff + 1'b1;
         if (!ev) begin
            if (!free_ok_ff) begin
               free_ok_ff  <= 1'b1;
               free_idx_ff <= idx_ff;
            end
         end else begin
            held_ff <= held_ff + 1'b1;
            if (!hit_ff && ek == key_ff) begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= idx_ff;
            end
            if (!vic_ok_ff || ec < vic_cnt_ff || (ec == vic_cnt_ff && er > vic_rank_ff)) begin
               vic_ok_ff   <= 1'b1;
               vic_idx_ff  <= idx_ff;
               vic_cnt_ff  <= ec;
               vic_rank_ff <= er;
            end
         end
      end
   end

   // commit
   logic          do_ins, use_vic, do_upd;
   logic [IB-1:0] slot;
   logic [RB-1:0] old_rank;
   assign is_hit  = hit_ff;
   assign use_vic = (held_ff >= cap_eff) || !free_ok_ff;
   assign do_ins  = (cap_eff != '0) && !is_hit && op_ff == lfu_pkg::OP_PUT &&
                    (!use_vic || vic_ok_ff);
   assign do_upd  = (cap_eff != '0) && (is_hit || do_ins);
   assign slot    = is_hit ? hit_idx_ff : (use_vic ? vic_idx_ff : free_idx_ff);
   assign old_rank = is_hit ? rank_ff[hit_idx_ff] :
                     (use_vic ? vic_rank_ff : RB'(held_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit && do_ins) begin
         valid_ff[slot] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && do_upd) begin
         for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
            if (IB'(i) != slot && valid_ff[i] && rank_ff[i] < old_rank)
               rank_ff[i] <= rank_ff[i] + 1'b1;
         end
         rank_ff[slot] <= '0;
         if (is_hit) begin
            if (count_ff[slot] != lfu_pkg::COUNT_MAX)
               count_ff[slot] <= count_ff[slot] + 1'b1;
         end else begin
            count_ff[slot] <= CB'(1);
            key_mem[slot]  <= key_ff;
         end
         if (op_ff == lfu_pkg::OP_PUT)
            data_mem[slot] <= value_ff;
      end
      if (cmd.commit) begin
         found       <= (cap_eff != '0) && is_hit;
         read_value  <= ((cap_eff != '0) && is_hit && op_ff == lfu_pkg::OP_GET) ?
                        data_mem[hit_idx_ff] : 32'd0;
         evicted     <= do_ins && use_vic;
         evicted_key <= (do_ins && use_vic) ? key_mem[vic_idx_ff] : 32'd0;
      end
   end
endmodule

[design/lfu_control.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfu_control
// Sequencer: accept, scan all entries, commit, hold the result.
// ---------------------------------------------------------------------------
module lfu_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output lfu_pkg::cmd_type    cmd,
   input  lfu_pkg::status_type status,
   output logic                load
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;
   localparam logic [1:0] ST_OUT = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign load = req_tvalid && req_tready;
   assign cmd.scan_start = load;
   assign cmd.scan_step = (state_ff == ST_SCAN);
   assign cmd.commit = (state_ff == ST_COMMIT);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (load) state_in = ST_SCAN;
         ST_SCAN:   if (status.scan_last) state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_OUT;
         ST_OUT:    if (rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

[design/lfu_cache_table.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfu_cache_table
// Fully associative key/value cache, LFU replacement with LRU tie break.
// ---------------------------------------------------------------------------
// One item at a time: accept, a serial scan of all 16 entries that
// finds the hit and the victim, a commit step, then the result is held
// until taken by the output handshake.
module lfu_cache_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // operation, lookup_key, write_value, zero fill
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [71:0] rsp_tdata,  // found, read_value, evicted, evicted_key, zero fill
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data    // capacity_in_use
);
   logic [lfu_pkg::CAP_BITS-1:0] cap_ff;
   lfu_pkg::cmd_type cmd;
   lfu_pkg::status_type status;
   logic load, found, evicted;
   logic [31:0] read_value, evicted_key;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) cap_ff <= lfu_pkg::CAP_BITS'(16);
      else if (csr_valid) cap_ff <= csr_data;
   end

   lfu_control u_ctl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .cmd, .status, .load
   );

   lfu_datapath u_dp (
      .clock, .reset, .cmd, .status, .load,
      .op(req_tdata[0]), .key(req_tdata[32:1]), .value(req_tdata[64:33]),
      .capacity(cap_ff), .found, .read_value, .evicted, .evicted_key
   );

   assign rsp_tdata = {6'd0, evicted_key, evicted, read_value, found};
endmodule

[design/lfu_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lfu_checker
// Port-level checks of the LFU cache table.
// ---------------------------------------------------------------------------
`include "lfu_cache_table_defines.svh"
module lfu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);
   `LFU_ASSERT_IMP(a_one_side, clock, reset, rsp_tvalid, !req_tready, "ready while result pending")
   `LFU_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result dropped")
   `LFU_ASSERT_NXT(a_busy, clock, reset, req_tvalid && req_tready, !req_tready && !rsp_tvalid, "no scan after accept")
   `LFU_ASSERT_IMP(a_evict_miss, clock, reset, rsp_tvalid && rsp_tdata[33], !rsp_tdata[0], "evict on hit")
endmodule

bind lfu_cache_table lfu_checker u_chk (.*);
